FILE: sv/dtoi_pkg.sv
// Package for the decimal text to int32 parser: byte classes, parse phases,
// token and payload types shared by the interface and all modules. No dependencies.
`default_nettype none

package dtoi_pkg;

  // Class of one text byte, as seen by the back end.
  typedef enum logic [2:0] {
    ClsSpace,
    ClsPlus,
    ClsMinus,
    ClsDigit,
    ClsOther
  } chr_class_e;

  // Parse phase: leading whitespace, sign and digit run, trailing part.
  typedef enum logic [1:0] {
    PhLead,
    PhRun,
    PhTail
  } parse_phase_e;

  localparam int unsigned MagW = 32;
  localparam logic [MagW-1:0] MagLimit = 32'h8000_0000;
  localparam logic [MagW-1:0] PosMax   = 32'h7FFF_FFFF;

  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;

  // Input payload: one byte of text with the last marker.
  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } in_item_t;

  // Result payload.
  typedef struct packed {
    logic signed [31:0] value;
    logic               ok;
  } out_item_t;

  // Classified byte as it travels through the queue.
  typedef struct packed {
    chr_class_e cls;
    logic [3:0] digit;
    logic       last;
  } tok_t;

endpackage

`default_nettype wire

FILE: sv/dtoi_stream_if.sv
// Valid/ready stream interface with a typed payload.
// The payload type is a parameter; dtoi_pkg supplies the types used at instantiation.
`default_nettype none

interface dtoi_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/dtoi_front.sv
// Front end: takes text bytes from the input stream and classifies them
// into tokens for the queue. Depends on dtoi_pkg and dtoi_stream_if.
`default_nettype none

module dtoi_front
  import dtoi_pkg::*;
(
  dtoi_stream_if.sink in_i,
  output logic        tok_valid_o,
  output tok_t        tok_o,
  input  logic        tok_ready_i
);

  logic [7:0] chr;
  logic       is_ws;
  logic       is_digit;
  logic [3:0] digit_off;

  assign chr       = in_i.data.char_in;
  assign is_ws     = (chr == ChrSpace) || ((chr >= ChrTab) && (chr <= ChrCr));
  assign is_digit  = (chr >= ChrZero) && (chr <= ChrNine);
  assign digit_off = 4'(chr - ChrZero);

  // Sort the byte into one class; the digit value rides along.
  always_comb begin
    tok_o.digit = digit_off;
    tok_o.last  = in_i.data.last;
    priority if (is_ws) begin
      tok_o.cls = ClsSpace;
    end else if (chr == ChrPlus) begin
      tok_o.cls = ClsPlus;
    end else if (chr == ChrMinus) begin
      tok_o.cls = ClsMinus;
    end else if (is_digit) begin
      tok_o.cls = ClsDigit;
    end else begin
      tok_o.cls = ClsOther;
    end
  end

  // A byte is transferred when the queue has room.
  assign tok_valid_o = in_i.valid;
  assign in_i.ready  = tok_ready_i;

endmodule

`default_nettype wire

FILE: sv/dtoi_queue.sv
// Small token queue between front and back end, registered output.
// Depends on dtoi_pkg for the token type.
`default_nettype none

module dtoi_queue
  import dtoi_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  tok_t push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output tok_t pop_data_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tok_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dtoi_back.sv
// Back end: runs the parse state machine and the saturating multiply-by-ten
// accumulator, and holds the result register. Depends on dtoi_pkg, dtoi_stream_if.
`default_nettype none

module dtoi_back
  import dtoi_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_valid_i,
  input  tok_t          tok_i,
  output logic          tok_ready_o,
  dtoi_stream_if.source out_o
);

  // Parse state.
  parse_phase_e    phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic            sat_q, sat_d;
  logic            seen_q, seen_d;
  logic            bad_q, bad_d;

  // Result register: the final parse state of one text.
  logic            res_valid_q;
  logic            res_neg_q, res_sat_q, res_seen_q, res_bad_q, res_run_q;
  logic [MagW-1:0] res_mag_q;

  logic            take;
  logic            do_digit;
  logic [MagW+3:0] mag_next;
  logic [MagW-1:0] value;
  logic            ovf;

  assign tok_ready_o = !res_valid_q || out_o.ready;
  assign take        = tok_valid_i && tok_ready_o;

  // Magnitude times ten plus the digit, as two shifted adds.
  assign mag_next = {3'b000, mag_q, 1'b0} + {1'b0, mag_q, 3'b000}
                  + {(MagW)'(0), tok_i.digit};

  // Next parse state for the incoming token.
  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    sat_d    = sat_q;
    bad_d    = bad_q;
    do_digit = 1'b0;
    unique case (phase_q)
      PhLead: begin
        unique case (tok_i.cls)
          ClsSpace: ;
          ClsPlus, ClsMinus: begin
            neg_d   = (tok_i.cls == ClsMinus);
            phase_d = PhRun;
          end
          ClsDigit: begin
            do_digit = 1'b1;
            phase_d  = PhRun;
          end
          default: begin
            bad_d   = 1'b1;
            phase_d = PhTail;
          end
        endcase
      end
      PhRun: begin
        priority if (tok_i.cls == ClsDigit) begin
          do_digit = 1'b1;
        end else if (tok_i.cls == ClsSpace) begin
          phase_d = PhTail;
        end else begin
          bad_d   = 1'b1;
          phase_d = PhTail;
        end
      end
      default: begin
        if (tok_i.cls != ClsSpace) begin
          bad_d = 1'b1;
        end
      end
    endcase
    mag_d  = mag_q;
    seen_d = seen_q;
    if (do_digit) begin
      seen_d = 1'b1;
      if (mag_next > {4'b0000, MagLimit}) begin
        mag_d = MagLimit;
        sat_d = 1'b1;
      end else begin
        mag_d = mag_next[MagW-1:0];
      end
    end
  end

  // Parse state register; a last token hands its state to the result and clears.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      sat_q   <= 1'b0;
      seen_q  <= 1'b0;
      bad_q   <= 1'b0;
    end else if (take) begin
      if (tok_i.last) begin
        phase_q <= PhLead;
        neg_q   <= 1'b0;
        mag_q   <= '0;
        sat_q   <= 1'b0;
        seen_q  <= 1'b0;
        bad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        mag_q   <= mag_d;
        sat_q   <= sat_d;
        seen_q  <= seen_d;
        bad_q   <= bad_d;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (take) begin
      res_valid_q <= tok_i.last;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take && tok_i.last) begin
      res_neg_q  <= neg_d;
      res_mag_q  <= mag_d;
      res_sat_q  <= sat_d;
      res_seen_q <= seen_d;
      res_bad_q  <= bad_d;
      res_run_q  <= (phase_d != PhLead);
    end
  end

  // Apply the sign and clamp to the signed 32-bit range.
  always_comb begin
    value = '0;
    ovf   = 1'b0;
    if (res_seen_q) begin
      if (res_neg_q) begin
        if (res_sat_q) begin
          value = MagLimit;
          ovf   = 1'b1;
        end else begin
          value = '0 - res_mag_q;
        end
      end else begin
        if (res_sat_q || res_mag_q[MagW-1]) begin
          value = PosMax;
          ovf   = 1'b1;
        end else begin
          value = res_mag_q;
        end
      end
    end
  end

  assign out_o.valid      = res_valid_q;
  assign out_o.data.value = value;
  assign out_o.data.ok    = res_run_q && res_seen_q && !res_bad_q && !ovf;

endmodule

`default_nettype wire

FILE: sv/decimal_text_to_int32_core.sv
// Top level of the streaming decimal text to int32 parser.
// Depends on dtoi_pkg, dtoi_stream_if, dtoi_front, dtoi_queue and dtoi_back.
`default_nettype none

// The block takes one text byte per cycle on in_i while no waiting result stalls
// it, with last marking the end of a text, and gives one result per text on out_o:
// the signed value, clamped to the 32-bit range, and ok, which is set only for a
// well-formed in-range number with optional surrounding whitespace and sign. Each
// byte passes the multiply-by-ten accumulate step in the back end; once the last
// byte is transferred, the result passes the queue register, then the result
// register. QueueDepth tokens buffer bytes while the result waits.

module decimal_text_to_int32_core
  import dtoi_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dtoi_stream_if.sink   in_i,
  dtoi_stream_if.source out_o
);

  logic tok_valid, tok_ready;
  tok_t tok;
  logic q_valid, q_ready;
  tok_t q_data;

  // Classification of incoming bytes.
  dtoi_front u_front (
    .in_i        (in_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_ready_i (tok_ready)
  );

  // Token queue between the two halves.
  dtoi_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (tok_valid),
    .push_data_i  (tok),
    .push_ready_o (tok_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_data),
    .pop_ready_i  (q_ready)
  );

  // Parse engine and result register.
  dtoi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (q_data),
    .tok_ready_o (q_ready),
    .out_o       (out_o)
  );

  // A token pushed into the queue is available on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valid && tok_ready) |=> q_valid)
    else $error("queue lost a pushed token");

  // The back end stalls only while a result waits to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !q_ready) |-> (out_o.valid && !out_o.ready))
    else $error("back end stalled without a pending result");

  // A new result follows only from a last token taken in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(q_valid && q_ready && q_data.last))
    else $error("result raised without a last token");

endmodule

`default_nettype wire

FILE: tb/sv/dtoi_result_checker.sv
// Checker for the decimal text to int32 parser: watches both stream channels,
// predicts the result of every text and compares it with what the block gives.
// Depends on dtoi_pkg for the payload types, phase codes and byte constants.
module dtoi_result_checker
  import dtoi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parser state as the predictor sees it.
  parse_phase_e    phase_q;
  logic            negative_q;
  logic            saturated_q;
  logic            seen_digit_q;
  logic            bad_char_q;
  logic [MagW-1:0] magnitude_q;

  // Results still owed by the block, oldest first.
  out_item_t expected_results[$];
  out_item_t oldest_result;

  task automatic clear_parse();
    phase_q      = PhLead;
    negative_q   = 1'b0;
    saturated_q  = 1'b0;
    seen_digit_q = 1'b0;
    bad_char_q   = 1'b0;
    magnitude_q  = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("checker: %s", msg);
    fail_count_o++;
  endtask

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChrSpace) || (c >= ChrTab && c <= ChrCr);
  endfunction

  // Multiply-by-ten accumulate, held at the limit once it is passed.
  task automatic accumulate_digit(input logic [3:0] d);
    logic [35:0] next_mag;
    next_mag = 36'(magnitude_q) * 36'd10 + 36'(d);
    if (next_mag > 36'(MagLimit)) begin
      magnitude_q = MagLimit;
      saturated_q = 1'b1;
    end else begin
      magnitude_q = next_mag[MagW-1:0];
    end
    seen_digit_q = 1'b1;
  endtask

  // Advance the parse by one byte and, on the last one, queue the result.
  task automatic parse_text_byte(input in_item_t item);
    logic            space;
    logic            digit;
    logic [3:0]      digit_val;
    logic [MagW-1:0] value;
    logic            overflow;
    out_item_t       res;
    space     = is_space(item.char_in);
    digit     = (item.char_in >= ChrZero) && (item.char_in <= ChrNine);
    digit_val = 4'(item.char_in - ChrZero);
    case (phase_q)
      PhLead: begin
        if (space) begin
          // Leading whitespace is skipped.
        end else if (item.char_in == ChrPlus || item.char_in == ChrMinus) begin
          negative_q = (item.char_in == ChrMinus);
          phase_q    = PhRun;
        end else if (digit) begin
          accumulate_digit(digit_val);
          phase_q = PhRun;
        end else begin
          bad_char_q = 1'b1;
          phase_q    = PhTail;
        end
      end
      PhRun: begin
        if (digit) begin
          accumulate_digit(digit_val);
        end else begin
          bad_char_q = bad_char_q | !space;
          phase_q    = PhTail;
        end
      end
      default: begin
        // Only whitespace may follow the digit run.
        bad_char_q = bad_char_q | !space;
      end
    endcase
    if (item.last) begin
      value    = '0;
      overflow = 1'b0;
      if (seen_digit_q) begin
        if (negative_q) begin
          if (saturated_q) begin
            value    = MagLimit;
            overflow = 1'b1;
          end else begin
            value = '0 - magnitude_q;
          end
        end else if (saturated_q || magnitude_q > PosMax) begin
          value    = PosMax;
          overflow = 1'b1;
        end else begin
          value = magnitude_q;
        end
      end
      res.value = value;
      res.ok    = (phase_q != PhLead) && seen_digit_q && !bad_char_q && !overflow;
      expected_results = {expected_results, res};
      clear_parse();
    end
  endtask

  // Results are checked before the input of the same edge is taken, so a
  // result can never be matched against a text that ends at that very edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d ok %0b",
                                    out_data_i.value, out_data_i.ok));
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_data_i.value !== oldest_result.value) begin
            report_mismatch($sformatf("value got %0d expected %0d",
                                      out_data_i.value, oldest_result.value));
          end
          if (out_data_i.ok !== oldest_result.ok) begin
            report_mismatch($sformatf("ok got %0b expected %0b for value %0d",
                                      out_data_i.ok, oldest_result.ok,
                                      oldest_result.value));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_text_byte(in_data_i);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: tb/sv/decimal_text_to_int32_core_tb.sv
// Top of the decimal text to int32 parser testbench: clock, reset, text stimulus
// and the verdict. Depends on dtoi_pkg, dtoi_stream_if, the block and dtoi_result_checker.
module decimal_text_to_int32_core_tb
  import dtoi_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned RandomItems  = 1450;
  localparam int unsigned SettleCycles = 8;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_bytes  = 0;
  int unsigned fail_count;
  int unsigned pending_count;
  logic [7:0]  text_buf[$];

  dtoi_stream_if #(.T(in_item_t))  in_if ();
  dtoi_stream_if #(.T(out_item_t)) out_if ();

  decimal_text_to_int32_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dtoi_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cycle budget for the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The result side stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Append one byte to the text under construction.
  function automatic void add_byte(input logic [7:0] ch);
    text_buf = {text_buf, ch};
  endfunction

  function automatic logic [7:0] rand_space();
    return ($urandom_range(3) == 0) ? ChrSpace : ChrTab + 8'($urandom_range(4));
  endfunction

  function automatic void add_spaces(input int unsigned n);
    repeat (n) add_byte(rand_space());
  endfunction

  function automatic void add_digits(input int unsigned n);
    repeat (n) add_byte(ChrZero + 8'($urandom_range(9)));
  endfunction

  function automatic void add_sign();
    case ($urandom_range(2))
      1: add_byte(ChrPlus);
      2: add_byte(ChrMinus);
      default: ;
    endcase
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // One random text: mostly well-formed numbers, some near the 32-bit edges,
  // the rest junk after digits, blank texts, bare signs and raw noise.
  function automatic void make_random_text();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 55) begin
      add_spaces($urandom_range(2));
      add_sign();
      add_digits(($urandom_range(7) == 0) ? $urandom_range(12, 10) : $urandom_range(9, 1));
      add_spaces($urandom_range(2));
    end else if (kind < 67) begin
      add_spaces($urandom_range(1));
      add_sign();
      case ($urandom_range(5))
        0: add_str("2147483647");
        1: add_str("2147483648");
        2: add_str("2147483649");
        3: add_str("4294967295");
        4: add_str("99999999999999");
        default: add_str("0000000000002147483648");
      endcase
      add_spaces($urandom_range(1));
    end else if (kind < 79) begin
      add_spaces($urandom_range(1));
      add_sign();
      add_digits($urandom_range(5, 1));
      add_spaces($urandom_range(1));
      add_byte(8'($urandom_range(255)));
      add_spaces($urandom_range(1));
    end else if (kind < 84) begin
      add_spaces($urandom_range(4, 1));
    end else if (kind < 89) begin
      add_spaces($urandom_range(1));
      add_byte(($urandom_range(1) == 0) ? ChrPlus : ChrMinus);
      if ($urandom_range(1) == 0) add_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)));
    end
  endfunction

  // One byte transfer, preceded by idle cycles at the rate of the current phase.
  task automatic push_byte(input logic [7:0] ch, input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{char_in: ch, last: is_last};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_text();
    int unsigned n;
    if (text_buf.size() == 0) add_byte(ChrSpace);
    n = text_buf.size();
    for (int unsigned i = 0; i < n; i++) push_byte(text_buf[i], i == n - 1);
    text_buf.delete();
  endtask

  task automatic send_str(input string s);
    add_str(s);
    send_text();
  endtask

  task automatic send_raw(input logic [7:0] ch);
    add_byte(ch);
    send_text();
  endtask

  // Hold the sender until every result owed has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
  endtask

  initial begin
    int unsigned base;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed texts: single digit, blank, byte extremes, bare signs,
    // every whitespace byte, junk after digits and a digit after a gap.
    send_str("0");
    send_str(" ");
    send_raw(8'h00);
    send_raw(8'hFF);
    send_str("+");
    send_str("-");
    send_str("-5");
    send_str("\t7\r");
    send_str("\n\v\f");
    send_str("4x");
    send_str("1 2");
    send_str("+9 ");
    send_str("x1");
    drain();

    // Random texts in four phases of input idling and result stalling.
    base = sent_bytes;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      while (sent_bytes < base + (p + 1) * RandomItems / 4) begin
        make_random_text();
        send_text();
        if ($urandom_range(24) == 0) drain();
      end
      drain();
    end

    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
